### hdl/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg: shared types and constants of the periodic timer table
// Function and status codes, field widths, controller command struct.
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam int TIMER_SLOTS_DEF = 16;
  localparam int FUNC_W = 3;
  localparam int ID_W   = 16;
  localparam int PER_W  = 31;
  localparam int TIME_W = 47;
  localparam int DL_W   = 48;
  localparam int ST_W   = 3;

  localparam logic [FUNC_W-1:0] FN_REG    = 3'd0;
  localparam logic [FUNC_W-1:0] FN_RM_ID  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_RM_OWN = 3'd2;
  localparam logic [FUNC_W-1:0] FN_TICK   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_REMAIN = 3'd4;
  localparam logic [FUNC_W-1:0] FN_NEXT   = 3'd5;

  localparam logic [ST_W-1:0] ST_DONE    = 3'd0;
  localparam logic [ST_W-1:0] ST_UPDATED = 3'd1;
  localparam logic [ST_W-1:0] ST_NOTFND  = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL    = 3'd3;
  localparam logic [ST_W-1:0] ST_FIRED   = 3'd4;
  localparam logic [ST_W-1:0] ST_NODUE   = 3'd5;

  localparam logic [PER_W-1:0] REM_MAX = {PER_W{1'b1}};

  // controller to datapath
  typedef struct packed {
    logic load;    // capture request
    logic clr;     // clear scan pointers and flags
    logic step;    // process slot at scan index
    logic wr_new;  // append captured entry or update it in place
    logic fin_rm;  // commit compaction count
  } ptt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_end;
    logic found;
    logic full;
    logic hit;     // current tick slot fired
  } ptt_sts_t;

endpackage

### hdl/periodic_timer_table.sv
// ----------------------------------------------------------------------------
// periodic_timer_table: ordered table of periodic timers
// Register, remove, tick and query requests over a packed slot table.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; unused function
// codes are dropped. Each request scans the table one slot per cycle.
// Results appear on out_* for one cycle with out_valid high and cannot be
// stalled; a tick gives one result per fired timer, or one no-due result
// if none fired, with out_last on the final one.
module periodic_timer_table #(
  parameter int TIMER_SLOTS = ptt_pkg::TIMER_SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [ptt_pkg::FUNC_W-1:0]  in_func,
  input  logic [ptt_pkg::ID_W-1:0]    in_timer_id,
  input  logic [ptt_pkg::PER_W-1:0]   in_period,
  input  logic [ptt_pkg::ID_W-1:0]    in_owner,
  input  logic [ptt_pkg::TIME_W-1:0]  in_current_time,
  output logic                        out_valid,
  output logic [ptt_pkg::ST_W-1:0]    out_status,
  output logic [ptt_pkg::PER_W-1:0]   out_value,
  output logic [ptt_pkg::ID_W-1:0]    out_fired_id,
  output logic [ptt_pkg::ID_W-1:0]    out_fired_owner,
  output logic                        out_last
);

  ptt_pkg::ptt_cmd_t cmd;
  ptt_pkg::ptt_sts_t sts;
  logic [ptt_pkg::FUNC_W-1:0] func_q;
  logic [ptt_pkg::PER_W-1:0]  best_q, rem_q;
  logic [ptt_pkg::ID_W-1:0]   hit_id, hit_owner;
  logic empty;

  ptt_ctrl u_ctrl (
    .clk, .rst_n, .start, .busy, .in_func, .func_q, .sts, .best_q, .rem_q,
    .hit_id, .hit_owner, .empty, .cmd, .out_valid, .out_status, .out_value,
    .out_fired_id, .out_fired_owner, .out_last
  );

  ptt_datapath #(.TIMER_SLOTS(TIMER_SLOTS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .in_func, .in_timer_id, .in_period, .in_owner,
    .in_current_time, .func_q, .best_q, .rem_q, .hit_id, .hit_owner, .empty
  );

endmodule

### hdl/ptt_datapath.sv
// ----------------------------------------------------------------------------
// ptt_datapath: slot storage and per-slot scan unit
// One slot per cycle is examined; compaction copies slot i to slot j.
// ----------------------------------------------------------------------------
module ptt_datapath #(
  parameter int TIMER_SLOTS = ptt_pkg::TIMER_SLOTS_DEF,
  parameter int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1,
  parameter int CW = $clog2(TIMER_SLOTS + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ptt_pkg::ptt_cmd_t           cmd,
  output ptt_pkg::ptt_sts_t           sts,
  input  logic [ptt_pkg::FUNC_W-1:0]  in_func,
  input  logic [ptt_pkg::ID_W-1:0]    in_timer_id,
  input  logic [ptt_pkg::PER_W-1:0]   in_period,
  input  logic [ptt_pkg::ID_W-1:0]    in_owner,
  input  logic [ptt_pkg::TIME_W-1:0]  in_current_time,
  output logic [ptt_pkg::FUNC_W-1:0]  func_q,
  output logic [ptt_pkg::PER_W-1:0]   best_q,
  output logic [ptt_pkg::PER_W-1:0]   rem_q,
  output logic [ptt_pkg::ID_W-1:0]    hit_id,
  output logic [ptt_pkg::ID_W-1:0]    hit_owner,
  output logic                        empty
);

  logic [ptt_pkg::ID_W-1:0]   id_r    [TIMER_SLOTS];
  logic [ptt_pkg::ID_W-1:0]   own_r   [TIMER_SLOTS];
  logic [ptt_pkg::PER_W-1:0]  per_r   [TIMER_SLOTS];
  logic [ptt_pkg::DL_W-1:0]   dl_r    [TIMER_SLOTS];
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] i_r, j_r;
  logic [ptt_pkg::FUNC_W-1:0] fn_r;
  logic [ptt_pkg::ID_W-1:0]   qid_r, qown_r;
  logic [ptt_pkg::PER_W-1:0]  qper_r;
  logic [ptt_pkg::TIME_W-1:0] now_r;
  logic found_r;
  logic [IW-1:0] fidx_r;
  logic [ptt_pkg::PER_W-1:0] best_r, rem_r;

  logic [IW-1:0] ix, jx;
  logic [ptt_pkg::DL_W-1:0] cur_dl, new_dl;
  logic signed [ptt_pkg::DL_W:0] diff;
  logic [ptt_pkg::PER_W-1:0] rem_sat;
  logic id_eq, own_eq, due;

  assign ix = i_r[IW-1:0];
  assign jx = j_r[IW-1:0];
  assign cur_dl = dl_r[ix];
  assign id_eq  = id_r[ix] == qid_r;
  assign own_eq = own_r[ix] == qown_r;
  assign due    = cur_dl <= {1'b0, now_r};
  assign new_dl = {1'b0, now_r} + {{(ptt_pkg::DL_W-ptt_pkg::PER_W){1'b0}}, per_r[ix]};
  assign diff   = $signed({1'b0, cur_dl}) - $signed({2'b00, now_r});

  // saturate remaining time
  always_comb begin
    if (diff[ptt_pkg::DL_W]) rem_sat = '0;
    else if (diff[ptt_pkg::DL_W-1:ptt_pkg::PER_W] != '0) rem_sat = ptt_pkg::REM_MAX;
    else rem_sat = diff[ptt_pkg::PER_W-1:0];
  end

  assign sts.scan_end = (i_r >= cnt_r);
  assign sts.found    = found_r;
  assign sts.full     = (cnt_r >= CW'(TIMER_SLOTS));
  assign sts.hit      = !sts.scan_end && due;

  assign func_q    = fn_r;
  assign best_q    = best_r;
  assign rem_q     = rem_r;
  assign hit_id    = id_r[ix];
  assign hit_owner = own_r[ix];
  assign empty     = (cnt_r == '0);

  // slot count on append or removal commit
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.wr_new && !found_r) cnt_nxt = cnt_r + 1'b1;
    else if (cmd.fin_rm) begin
      if (fn_r == ptt_pkg::FN_RM_ID) cnt_nxt = cnt_r - 1'b1;
      else cnt_nxt = j_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // capture request, scan slots, update storage
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fn_r   <= in_func;
      qid_r  <= in_timer_id;
      qper_r <= in_period;
      qown_r <= in_owner;
      now_r  <= in_current_time;
    end
    if (cmd.clr) begin
      i_r     <= '0;
      j_r     <= '0;
      found_r <= 1'b0;
      fidx_r  <= '0;
      best_r  <= ptt_pkg::REM_MAX;
      rem_r   <= '0;
    end else if (cmd.step && !sts.scan_end) begin
      i_r <= i_r + 1'b1;
      unique case (fn_r)
        ptt_pkg::FN_REG, ptt_pkg::FN_REMAIN: begin
          if (!found_r && id_eq) begin
            found_r <= 1'b1;
            fidx_r  <= ix;
            rem_r   <= rem_sat;
          end
        end
        ptt_pkg::FN_RM_ID: begin
          if (found_r) begin
            id_r[jx]  <= id_r[ix];
            own_r[jx] <= own_r[ix];
            per_r[jx] <= per_r[ix];
            dl_r[jx]  <= dl_r[ix];
            j_r <= j_r + 1'b1;
          end else if (id_eq) begin
            found_r <= 1'b1;
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        ptt_pkg::FN_RM_OWN: begin
          if (own_eq) begin
            found_r <= 1'b1;
          end else begin
            id_r[jx]  <= id_r[ix];
            own_r[jx] <= own_r[ix];
            per_r[jx] <= per_r[ix];
            dl_r[jx]  <= dl_r[ix];
            j_r <= j_r + 1'b1;
          end
        end
        ptt_pkg::FN_TICK: begin
          if (due) begin
            dl_r[ix] <= new_dl;
            found_r  <= 1'b1;
          end
        end
        ptt_pkg::FN_NEXT: begin
          if (rem_sat < best_r) best_r <= rem_sat;
        end
        default: ;
      endcase
    end
    // register: update in place or append
    if (cmd.wr_new) begin
      if (found_r) begin
        own_r[fidx_r] <= qown_r;
        per_r[fidx_r] <= qper_r;
        dl_r[fidx_r]  <= {1'b0, now_r} + {{(ptt_pkg::DL_W-ptt_pkg::PER_W){1'b0}}, qper_r};
      end else begin
        id_r[cnt_r[IW-1:0]]  <= qid_r;
        own_r[cnt_r[IW-1:0]] <= qown_r;
        per_r[cnt_r[IW-1:0]] <= qper_r;
        dl_r[cnt_r[IW-1:0]]  <= {1'b0, now_r} + {{(ptt_pkg::DL_W-ptt_pkg::PER_W){1'b0}}, qper_r};
      end
    end
  end

endmodule

### hdl/ptt_ctrl.sv
// ----------------------------------------------------------------------------
// ptt_ctrl: sequencer of the periodic timer table
// Accepts a request, walks the slots at most once and issues the results.
// ----------------------------------------------------------------------------
module ptt_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [ptt_pkg::FUNC_W-1:0]  in_func,
  input  logic [ptt_pkg::FUNC_W-1:0]  func_q,
  input  ptt_pkg::ptt_sts_t           sts,
  input  logic [ptt_pkg::PER_W-1:0]   best_q,
  input  logic [ptt_pkg::PER_W-1:0]   rem_q,
  input  logic [ptt_pkg::ID_W-1:0]    hit_id,
  input  logic [ptt_pkg::ID_W-1:0]    hit_owner,
  input  logic                        empty,
  output ptt_pkg::ptt_cmd_t           cmd,
  output logic                        out_valid,
  output logic [ptt_pkg::ST_W-1:0]    out_status,
  output logic [ptt_pkg::PER_W-1:0]   out_value,
  output logic [ptt_pkg::ID_W-1:0]    out_fired_id,
  output logic [ptt_pkg::ID_W-1:0]    out_fired_owner,
  output logic                        out_last
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic pend_r, pend_nxt;  // tick result held for last marking
  logic [ptt_pkg::ID_W-1:0] pid_r, pown_r;
  logic ov_nxt, ol_nxt;
  logic [ptt_pkg::ST_W-1:0] os_nxt;
  logic [ptt_pkg::PER_W-1:0] oval_nxt;
  logic [ptt_pkg::ID_W-1:0] oid_nxt, oown_nxt;
  logic accept;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy && (in_func <= ptt_pkg::FN_NEXT);

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    cmd       = '0;
    ov_nxt    = 1'b0;
    ol_nxt    = 1'b1;
    os_nxt    = ptt_pkg::ST_DONE;
    oval_nxt  = '0;
    oid_nxt   = '0;
    oown_nxt  = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load  = 1'b1;
          cmd.clr   = 1'b1;
          pend_nxt  = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        // early exit once a register or remain id lookup hits
        if (sts.scan_end || (sts.found && (func_q == ptt_pkg::FN_REG ||
            func_q == ptt_pkg::FN_REMAIN))) begin
          cmd.step  = 1'b0;
          state_nxt = S_DONE;
        end else if (func_q == ptt_pkg::FN_TICK && sts.hit) begin
          // emit previous fired slot, hold this one
          if (pend_r) begin
            ov_nxt   = 1'b1;
            ol_nxt   = 1'b0;
            os_nxt   = ptt_pkg::ST_FIRED;
            oid_nxt  = pid_r;
            oown_nxt = pown_r;
          end
          pend_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        ov_nxt    = 1'b1;
        unique case (func_q)
          ptt_pkg::FN_REG: begin
            if (sts.found) begin
              os_nxt = ptt_pkg::ST_UPDATED;
              cmd.wr_new = 1'b1;
            end else if (sts.full) begin
              os_nxt = ptt_pkg::ST_FULL;
            end else begin
              cmd.wr_new = 1'b1;
            end
          end
          ptt_pkg::FN_RM_ID, ptt_pkg::FN_RM_OWN: begin
            if (sts.found) cmd.fin_rm = 1'b1;
            else os_nxt = ptt_pkg::ST_NOTFND;
          end
          ptt_pkg::FN_TICK: begin
            if (pend_r) begin
              os_nxt   = ptt_pkg::ST_FIRED;
              oid_nxt  = pid_r;
              oown_nxt = pown_r;
            end else begin
              os_nxt = ptt_pkg::ST_NODUE;
            end
          end
          ptt_pkg::FN_REMAIN: begin
            if (sts.found) oval_nxt = rem_q;
            else os_nxt = ptt_pkg::ST_NOTFND;
          end
          default: begin
            if (empty) os_nxt = ptt_pkg::ST_NOTFND;
            else oval_nxt = best_q;
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      pend_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pend_r    <= pend_nxt;
      out_valid <= ov_nxt;
    end
  end

  // hold fired slot and result payload
  always_ff @(posedge clk) begin
    if (state_r == S_SCAN && sts.hit && func_q == ptt_pkg::FN_TICK) begin
      pid_r  <= hit_id;
      pown_r <= hit_owner;
    end
    out_status      <= os_nxt;
    out_value       <= oval_nxt;
    out_fired_id    <= oid_nxt;
    out_fired_owner <= oown_nxt;
    out_last        <= ol_nxt;
  end

endmodule
